FILE: rtl/core/cla_pkg.sv
// Shared types, codes and constants of the circular log region allocator.
package cla_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned SIZE_W     = 40;
    localparam int unsigned PORT_OFF_W = 40;
    localparam int unsigned CFG_W      = 41;
    localparam int unsigned STATUS_W   = 3;

    // Default sizing of the live region table and of stored offsets.
    localparam int unsigned ENTRIES_DEF     = 64;
    localparam int unsigned OFFSET_BITS_DEF = 40;

    // Register values after reset.
    localparam logic [CFG_W-1:0]      CAPACITY_RESET    = 41'd1073741824;
    localparam logic [PORT_OFF_W-1:0] LOG_RESERVE_RESET = 40'd0;

    // Request kinds.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_CAPACITY    = 1'b0;
    localparam logic CFG_LOG_RESERVE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 3'd0,
        STATUS_NOSPACE  = 3'd1,
        STATUS_NOTFOUND = 3'd2,
        STATUS_EMPTY    = 3'd3,
        STATUS_FULL     = 3'd4
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // capture the request fields
        logic alloc_sum;     // form both candidate end offsets
        logic alloc_finish;  // decide and commit an allocation
        logic free_empty;    // finish a free on an empty table
        logic scan_init;     // reset the table scan
        logic scan_step;     // advance the table scan by one entry
        logic free_finish;   // finish a free after the scan
    } cla_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic scan_done;
    } cla_stat_t;

endpackage

FILE: rtl/core/cla_ctrl.sv
// Controller state machine of the circular log region allocator.
module cla_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                mode,
    input  cla_pkg::cla_stat_t  stat,
    output cla_pkg::cla_cmd_t   cmd,
    output logic                busy,
    output logic                done
);
    import cla_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC_SUM,
        ST_ALLOC_CHK,
        ST_FREE_START,
        ST_FREE_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (mode == MODE_FREE) ? ST_FREE_START : ST_ALLOC_SUM;
                end
            end
            ST_ALLOC_SUM:
            begin
                cmd.alloc_sum = 1'b1;
                state_next    = ST_ALLOC_CHK;
            end
            ST_ALLOC_CHK:
            begin
                cmd.alloc_finish = 1'b1;
                done_next        = 1'b1;
                state_next       = ST_IDLE;
            end
            ST_FREE_START:
            begin
                if (stat.count_zero)
                begin
                    cmd.free_empty = 1'b1;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_FREE_SCAN;
                end
            end
            ST_FREE_SCAN:
            begin
                if (stat.scan_done)
                begin
                    cmd.free_finish = 1'b1;
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

FILE: rtl/core/cla_dp.sv
// Datapath of the circular log region allocator: registers, sums, table memory and results.
module cla_dp #(
    parameter int unsigned ENTRIES     = cla_pkg::ENTRIES_DEF,
    parameter int unsigned OFFSET_BITS = cla_pkg::OFFSET_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cla_pkg::cla_cmd_t                 cmd,
    output cla_pkg::cla_stat_t                stat,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [cla_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [cla_pkg::SIZE_W-1:0]        alloc_size,
    input  logic [cla_pkg::PORT_OFF_W-1:0]    free_offset,
    output logic [cla_pkg::STATUS_W-1:0]      status,
    output logic [cla_pkg::PORT_OFF_W-1:0]    granted_offset,
    output logic                              wrapped
);
    import cla_pkg::*;

    // Sums and limits carry one bit beyond the wider of offset and size.
    localparam int unsigned CW    = ((OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W) + 1;
    localparam int unsigned AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

    localparam logic [CW-1:0]    SPAN     = CW'(1) << OFFSET_BITS;
    localparam logic [CW-1:0]    CAP_RST  = CW'(CAPACITY_RESET);
    localparam logic [CW-1:0]    LIM_RST  = (CAP_RST < SPAN) ? CAP_RST : SPAN;
    localparam logic [CW-1:0]    RES_RSTW = CW'(LOG_RESERVE_RESET);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    // Configuration and allocator state.
    logic [CW-1:0]          limit_reg;
    logic [OFFSET_BITS-1:0] reserve_reg;
    logic [OFFSET_BITS-1:0] next_free_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [OFFSET_BITS-1:0] head_reg;

    // Request and intermediate registers.
    logic [SIZE_W-1:0]      size_reg;
    logic [OFFSET_BITS-1:0] target_reg;
    logic [CW-1:0]          sum_a_reg;
    logic [CW-1:0]          sum_b_reg;

    // Scan registers.
    logic [CNT_W-1:0]       rd_idx_reg;
    logic                   pend_reg;
    logic [AW-1:0]          pend_idx_reg;
    logic                   found_reg;

    // Result registers.
    status_t                status_reg;
    logic [PORT_OFF_W-1:0]  granted_reg;
    logic                   wrapped_reg;

    // Table memory.
    logic [OFFSET_BITS-1:0] live_mem [ENTRIES];
    logic [OFFSET_BITS-1:0] mem_rdata_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [OFFSET_BITS-1:0] mem_wdata;
    logic                   mem_re;

    // Combinational helpers.
    logic [CW-1:0]          cap_wide;
    logic [CW-1:0]          res_wide;
    logic [CW-1:0]          target_wide;
    logic [CW-1:0]          start_wide;
    logic                   wrap;
    logic                   nospace;
    logic                   full;
    logic                   commit;
    logic [OFFSET_BITS-1:0] start_off;
    logic [OFFSET_BITS-1:0] end_off;
    logic                   shift_wr;
    logic                   match;

    assign cap_wide    = CW'(cfg_wdata);
    assign res_wide    = CW'(cfg_wdata[PORT_OFF_W-1:0]);
    assign target_wide = CW'(free_offset);

    // Allocation decision from the registered sums.
    assign wrap      = (sum_a_reg >= limit_reg);
    assign nospace   = (sum_b_reg >= limit_reg)
                     || ((count_reg != '0) && (sum_b_reg > CW'(head_reg)));
    assign full      = (count_reg == FULL_CNT);
    assign commit    = cmd.alloc_finish && !full && !(wrap && nospace);
    assign start_off = wrap ? reserve_reg : next_free_reg;
    assign end_off   = wrap ? sum_b_reg[OFFSET_BITS-1:0] : sum_a_reg[OFFSET_BITS-1:0];
    assign start_wide = CW'(start_off);

    // The scan reads one entry a cycle; once the target is found, each later
    // entry is written back one place lower.
    assign mem_re   = cmd.scan_step && (rd_idx_reg < count_reg);
    assign match    = (mem_rdata_reg == target_reg);
    assign shift_wr = cmd.scan_step && pend_reg && found_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = count_reg[AW-1:0];
        mem_wdata = start_off;
        if (commit)
        begin
            mem_we = 1'b1;
        end
        else if (shift_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = pend_idx_reg - AW'(1);
            mem_wdata = mem_rdata_reg;
        end
    end

    // Table memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            live_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= live_mem[rd_idx_reg[AW-1:0]];
        end
    end

    // Configuration registers and allocator control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIM_RST;
            reserve_reg   <= RES_RSTW[OFFSET_BITS-1:0];
            next_free_reg <= RES_RSTW[OFFSET_BITS-1:0];
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CAPACITY:
                    begin
                        limit_reg <= (cap_wide < SPAN) ? cap_wide : SPAN;
                    end
                    CFG_LOG_RESERVE:
                    begin
                        reserve_reg <= res_wide[OFFSET_BITS-1:0];
                    end
                    default:
                    begin
                        limit_reg <= limit_reg;
                    end
                endcase
            end
            if (commit)
            begin
                count_reg     <= count_reg + CNT_W'(1);
                next_free_reg <= end_off;
            end
            if (cmd.free_finish && found_reg)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.scan_init)
            begin
                rd_idx_reg <= '0;
                pend_reg   <= 1'b0;
                found_reg  <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                pend_reg <= mem_re;
                if (mem_re)
                begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
                if (pend_reg && !found_reg && match)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // Request capture, sums, oldest entry and results.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            size_reg   <= alloc_size;
            target_reg <= target_wide[OFFSET_BITS-1:0];
        end
        if (cmd.alloc_sum)
        begin
            sum_a_reg <= CW'(next_free_reg) + CW'(size_reg);
            sum_b_reg <= CW'(reserve_reg) + CW'(size_reg);
        end
        if (cmd.scan_step)
        begin
            pend_idx_reg <= rd_idx_reg[AW-1:0];
        end
        if (mem_we && (mem_waddr == '0))
        begin
            head_reg <= mem_wdata;
        end
        if (cmd.alloc_finish)
        begin
            if (full)
            begin
                status_reg  <= STATUS_FULL;
                granted_reg <= '0;
                wrapped_reg <= 1'b0;
            end
            else if (wrap && nospace)
            begin
                status_reg  <= STATUS_NOSPACE;
                granted_reg <= '0;
                wrapped_reg <= 1'b0;
            end
            else
            begin
                status_reg  <= STATUS_OK;
                granted_reg <= start_wide[PORT_OFF_W-1:0];
                wrapped_reg <= wrap;
            end
        end
        if (cmd.free_empty)
        begin
            status_reg  <= STATUS_EMPTY;
            granted_reg <= '0;
            wrapped_reg <= 1'b0;
        end
        if (cmd.free_finish)
        begin
            status_reg  <= found_reg ? STATUS_OK : STATUS_NOTFOUND;
            granted_reg <= '0;
            wrapped_reg <= 1'b0;
        end
    end

    assign stat.count_zero = (count_reg == '0);
    assign stat.scan_done  = (rd_idx_reg == count_reg) && !pend_reg;

    assign status         = status_reg;
    assign granted_offset = granted_reg;
    assign wrapped        = wrapped_reg;

endmodule

FILE: rtl/core/circular_log_region_allocator.sv
// Top level of the circular log region allocator.
//
// Requests are commands: a request is taken at a rising edge with start high
// and busy low. mode selects allocate (alloc_size bytes) or free (the region
// starting at free_offset). Each request gives exactly one result transfer:
// status, granted_offset and wrapped are valid for the single cycle in which
// done is high, and the receiver cannot hold them off.
// An allocate forms both candidate end offsets in ALLOC_SUM and decides in
// ALLOC_CHK. A free on an empty table finishes in FREE_START; any other free
// scans the table in FREE_SCAN, reading one entry a cycle through the table
// memory's read port and writing later entries one place lower behind the
// match through its write port.
// busy falls together with done, so a new request may be taken in the cycle
// its predecessor's result is shown. Configuration writes (cfg_we,
// cfg_index, cfg_wdata) take effect at once; the user must make them only
// while the block is idle (unenforced). Reset clears the table and sets the
// bump pointer to the reset log reserve; no clearing pass is needed.
module circular_log_region_allocator #(
    parameter int unsigned ENTRIES     = cla_pkg::ENTRIES_DEF,
    parameter int unsigned OFFSET_BITS = cla_pkg::OFFSET_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              mode,
    input  logic [cla_pkg::SIZE_W-1:0]        alloc_size,
    input  logic [cla_pkg::PORT_OFF_W-1:0]    free_offset,
    output logic                              done,
    output logic [cla_pkg::STATUS_W-1:0]      status,
    output logic [cla_pkg::PORT_OFF_W-1:0]    granted_offset,
    output logic                              wrapped,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [cla_pkg::CFG_W-1:0]         cfg_wdata
);
    import cla_pkg::*;

    cla_cmd_t  cmd;
    cla_stat_t stat;

    // Sequencing of each request.
    cla_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Pointer arithmetic, live region table and result registers.
    cla_dp #(
        .ENTRIES     (ENTRIES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .alloc_size     (alloc_size),
        .free_offset    (free_offset),
        .status         (status),
        .granted_offset (granted_offset),
        .wrapped        (wrapped)
    );

`ifndef SYNTHESIS
    // A result only follows a request in progress, and ends it.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result strobe without a request in progress");

    // Work only begins on a taken request.
    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    // Only a successful allocation may report a wrap.
    a_wrap_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && wrapped) |-> (status == STATUS_OK))
        else $error("wrap reported on a failed request");

    // A failed request grants nothing.
    a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STATUS_OK)) |-> (granted_offset == '0))
        else $error("offset granted on a failed request");
`endif

endmodule
